// File: hw/rtl/sqvt_pkg.sv
// ============================================================================
// sqvt_pkg: shared types and helpers for the sprite quad vertex transform
// Word layouts, register and corner codes, saturation and trig argument setup.
// ============================================================================
package sqvt_pkg;

    localparam int NUM_W     = 39;   // offset division numerator
    localparam int DEN_W     = 19;   // divisor, up to 64 * 8191
    localparam int QUO_W     = 18;   // quotient bits after offset
    localparam int P_W       = 36;   // rotated position, Q.20
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_W = 3'd0,
        REG_SCREEN_H = 3'd1,
        REG_TEX_W    = 3'd2,
        REG_TEX_H    = 3'd3
    } cfg_reg_t;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [15:0] dest_w;
        logic signed [15:0] dest_h;
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic signed [15:0] src_w;
        logic signed [15:0] src_h;
        logic [15:0]        turn_angle;
        logic [31:0]        color_rgba;
    } sprite_t;

    typedef struct packed {
        logic [1:0]         corner_index;
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [31:0]        vertex_color;
        logic               last_corner;
    } vertex_t;

    // Quarter-wave argument of the sine polynomial
    typedef struct packed {
        logic [15:0] x;
        logic        neg;
    } trig_in_t;

    // Divider result: offset quotient plus out-of-range flags
    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic             lo;
        logic             hi;
    } div_res_t;

    function automatic trig_in_t trig_arg(input logic [15:0] ph);
        trig_in_t    a;
        logic [14:0] rr;
        rr = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
        a.x   = {rr, 1'b0};
        a.neg = ph[15];
        return a;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = SAT_MAX;
        else if (v < -20'sd32768)
            r = SAT_MIN;
        else
            r = v[15:0];
        return r;
    endfunction

    // Remove the quotient offset of 2^17
    function automatic logic signed [19:0] div_val(input div_res_t d);
        return $signed({2'b00, d.q}) - 20'sd131072;
    endfunction

endpackage

// File: hw/rtl/sqvt_dly.sv
// ============================================================================
// sqvt_dly: enabled delay line
// Carries side data alongside the arithmetic stages.
// ============================================================================
module sqvt_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         adv,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] sr_reg [N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];
endmodule

// File: hw/rtl/sqvt_trig.sv
// ============================================================================
// sqvt_trig: four-stage sine polynomial
// Q1.15 quarter-wave sine with quadrant sign, one multiply per stage.
// ============================================================================
module sqvt_trig (
    input  logic                clk,
    input  logic                adv,
    input  sqvt_pkg::trig_in_t  arg,
    output logic signed [15:0]  val
);
    import sqvt_pkg::*;

    logic [15:0] b_x_reg, b_x2_reg, c_x_reg, c_x2_reg, d_x_reg;
    logic        b_neg_reg, c_neg_reg, d_neg_reg;
    logic [13:0] c_t1_reg;
    logic [14:0] d_t2_reg;
    logic signed [15:0] e_val_reg;

    logic [31:0] m0;
    logic [26:0] m1;
    logic [29:0] m2;
    logic [30:0] m3;
    logic [16:0] y;

    assign m0 = 32'(arg.x) * 32'(arg.x);
    assign m1 = 27'(b_x2_reg) * 27'd1160;
    assign m2 = 30'(c_t1_reg) * 30'(c_x2_reg);
    assign m3 = 31'(d_x_reg) * 31'(d_t2_reg);
    assign y  = m3[30:14];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_x_reg   <= arg.x;
            b_neg_reg <= arg.neg;
            b_x2_reg  <= m0[30:15];
            c_x_reg   <= b_x_reg;
            c_neg_reg <= b_neg_reg;
            c_x2_reg  <= b_x2_reg;
            c_t1_reg  <= 14'd10512 - 14'(m1 >> 15);
            d_x_reg   <= c_x_reg;
            d_neg_reg <= c_neg_reg;
            d_t2_reg  <= 15'd25736 - 15'(m2 >> 15);
            if (y > 17'd32767)
                e_val_reg <= d_neg_reg ? -SAT_MAX : SAT_MAX;
            else
                e_val_reg <= d_neg_reg ? -$signed(y[15:0]) : $signed(y[15:0]);
        end
    end

    assign val = e_val_reg;
endmodule

// File: hw/rtl/sqvt_div.sv
// ============================================================================
// sqvt_div: pipelined restoring divider
// One quotient bit per stage; flags numerators outside the quotient range.
// ============================================================================
module sqvt_div (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [sqvt_pkg::NUM_W-1:0]    num,
    input  logic [sqvt_pkg::DEN_W-1:0]    den,
    output sqvt_pkg::div_res_t            res
);
    import sqvt_pkg::*;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic             lo_reg  [QUO_W];
    logic             hi_reg  [QUO_W];
    logic [NUM_W-1:0] top_den;

    assign top_den = NUM_W'(den) << QUO_W;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int B = QUO_W - 1 - i;
        logic [NUM_W-1:0] rem_in, dsh;
        logic [QUO_W-1:0] quo_in;
        logic             lo_in, hi_in, ge;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign quo_in = '0;
            assign lo_in  = num[NUM_W-1];
            assign hi_in  = !num[NUM_W-1] && (num >= top_den);
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign hi_in  = hi_reg[i-1];
        end

        assign dsh = NUM_W'(den) << B;
        assign ge  = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= ge ? rem_in - dsh : rem_in;
                quo_reg[i] <= quo_in | (QUO_W'(ge) << B);
                lo_reg[i]  <= lo_in;
                hi_reg[i]  <= hi_in;
            end
        end
    end

    assign res.q  = quo_reg[QUO_W-1];
    assign res.lo = lo_reg[QUO_W-1];
    assign res.hi = hi_reg[QUO_W-1];
endmodule

// File: hw/rtl/sprite_quad_vertex_transform_unit.sv
// ============================================================================
// sprite_quad_vertex_transform_unit: sprite quad to four NDC vertices
// Rotates the corners about the centre, maps to NDC and texture space.
// ============================================================================
// Throughput: one vertex word per cycle unless a held output word stalls
//   every stage; the 27-stage datapath takes a corner each cycle it
//   advances, and a new sprite word is taken only while the issuer is
//   empty or issuing the last corner of the word before.
// Reset: rst_n is asynchronous, active low; clears valid state and loads
//   the size registers with 1280, 720, 8, 8.
module sprite_quad_vertex_transform_unit #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sprite_valid,
    output logic                              sprite_ready,
    input  sqvt_pkg::sprite_t                 sprite,
    output logic                              vertex_valid,
    input  logic                              vertex_ready,
    output sqvt_pkg::vertex_t                 vertex,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sqvt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sqvt_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import sqvt_pkg::*;

    // Stage map: 0 issue, 1-4 sine, 5 products, 6 sums, 7 numerators,
    // 8-25 divider, 26 output register.
    localparam int NST = 27;
    // Truncate the angle to its top table bits
    localparam logic [15:0] PH_MASK = ~16'((1 << (16 - TRIG_TABLE_BITS)) - 1);

    // ------------------------------------------------------------------
    // Size registers; a zero reads as one
    // ------------------------------------------------------------------
    logic [CFG_DAT_W-1:0] scr_w_reg, scr_h_reg, tex_w_reg, tex_h_reg;
    logic [CFG_DAT_W-1:0] w_eff, h_eff, tw_eff, th_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 13'd1280;
            scr_h_reg <= 13'd720;
            tex_w_reg <= 13'd8;
            tex_h_reg <= 13'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_W: scr_w_reg <= cfg_data;
                REG_SCREEN_H: scr_h_reg <= cfg_data;
                REG_TEX_W:    tex_w_reg <= cfg_data;
                REG_TEX_H:    tex_h_reg <= cfg_data;
                default:      ; // drop writes to unknown indexes
            endcase
        end
    end

    assign w_eff  = (scr_w_reg == '0) ? 13'd1 : scr_w_reg;
    assign h_eff  = (scr_h_reg == '0) ? 13'd1 : scr_h_reg;
    assign tw_eff = (tex_w_reg == '0) ? 13'd1 : tex_w_reg;
    assign th_eff = (tex_h_reg == '0) ? 13'd1 : tex_h_reg;

    // Divisors are 2d; numerators carry d (rounding) plus 2^17 * 2d (offset
    // that keeps the dividend positive over the useful quotient range).
    logic [DEN_W-1:0] den_x, den_y, den_u, den_v;
    logic [NUM_W-1:0] dx_ext, dy_ext, du_ext, dv_ext;
    logic [NUM_W-1:0] k_x, k_y, k_u, k_v;

    assign den_x  = DEN_W'({w_eff, 6'b0});
    assign den_y  = DEN_W'({h_eff, 6'b0});
    assign den_u  = DEN_W'({tw_eff, 1'b0});
    assign den_v  = DEN_W'({th_eff, 1'b0});
    assign dx_ext = NUM_W'({w_eff, 5'b0});
    assign dy_ext = NUM_W'({h_eff, 5'b0});
    assign du_ext = NUM_W'(tw_eff);
    assign dv_ext = NUM_W'(th_eff);
    assign k_x    = (dx_ext << 18) + dx_ext;
    assign k_y    = (dy_ext << 18) + dy_ext;
    assign k_u    = (du_ext << 18) + du_ext;
    assign k_v    = (dv_ext << 18) + dv_ext;

    // ------------------------------------------------------------------
    // Pipeline control: one global advance, which drops only while the output
    // register holds a word not yet taken; every stage then holds its word.
    // ------------------------------------------------------------------
    logic       vld_reg [NST];
    logic       adv;
    logic       spr_vld_reg;
    logic [1:0] corner_reg;
    sprite_t    spr_reg;
    logic       spr_take;

    assign adv          = !vld_reg[NST-1] || vertex_ready;
    assign sprite_ready = !spr_vld_reg || (adv && corner_reg == CORNER_BR);
    assign spr_take     = sprite_valid && sprite_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_vld_reg <= 1'b0;
            corner_reg  <= CORNER_TL;
        end
        else if (spr_take)
        begin
            spr_vld_reg <= 1'b1;
            corner_reg  <= CORNER_TL;
        end
        else if (adv && spr_vld_reg)
        begin
            // Advance to the next corner; release the word after the last
            corner_reg <= corner_reg + 2'd1;
            if (corner_reg == CORNER_BR)
                spr_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spr_take)
            spr_reg <= sprite;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= spr_vld_reg;
            for (int k = 1; k < NST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: corner setup
    // ------------------------------------------------------------------
    logic               right, bottom;
    logic signed [16:0] dw17, dh17, sx17, sy17, rx, ry, su, sv;
    logic signed [17:0] cx5, cy5;
    logic [15:0]        ph;
    logic [NUM_W-1:0]   su_ext, sv_ext;

    assign right  = corner_reg[0];
    assign bottom = corner_reg[1];
    assign dw17   = {spr_reg.dest_w[15], spr_reg.dest_w};
    assign dh17   = {spr_reg.dest_h[15], spr_reg.dest_h};
    assign sx17   = {spr_reg.src_x[15], spr_reg.src_x};
    assign sy17   = {spr_reg.src_y[15], spr_reg.src_y};
    assign rx     = right  ? dw17 : -dw17;
    assign ry     = bottom ? dh17 : -dh17;
    assign su     = right  ? sx17 + {spr_reg.src_w[15], spr_reg.src_w} : sx17;
    assign sv     = bottom ? sy17 + {spr_reg.src_h[15], spr_reg.src_h} : sy17;
    assign cx5    = {spr_reg.dest_x[15], spr_reg.dest_x, 1'b0}
                  + {{2{spr_reg.dest_w[15]}}, spr_reg.dest_w};
    assign cy5    = {spr_reg.dest_y[15], spr_reg.dest_y, 1'b0}
                  + {{2{spr_reg.dest_h[15]}}, spr_reg.dest_h};
    assign ph     = spr_reg.turn_angle & PH_MASK;
    assign su_ext = {{(NUM_W-26){su[16]}}, su, 9'b0};
    assign sv_ext = {{(NUM_W-26){sv[16]}}, sv, 9'b0};

    trig_in_t           a_sin_reg, a_cos_reg;
    logic signed [16:0] a_rx_reg, a_ry_reg;
    logic signed [17:0] a_cx_reg, a_cy_reg;
    logic [NUM_W-1:0]   a_nu_reg, a_nv_reg;
    logic [1:0]         a_corner_reg;
    logic [31:0]        a_color_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sin_reg    <= trig_arg(ph);
            a_cos_reg    <= trig_arg(ph + 16'h4000);
            a_rx_reg     <= rx;
            a_ry_reg     <= ry;
            a_cx_reg     <= cx5;
            a_cy_reg     <= cy5;
            a_nu_reg     <= su_ext + k_u;
            a_nv_reg     <= sv_ext + k_v;
            a_corner_reg <= corner_reg;
            a_color_reg  <= spr_reg.color_rgba;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-4: sine and cosine
    // ------------------------------------------------------------------
    logic signed [15:0] s_val, c_val;

    sqvt_trig u_sin (.clk(clk), .adv(adv), .arg(a_sin_reg), .val(s_val));
    sqvt_trig u_cos (.clk(clk), .adv(adv), .arg(a_cos_reg), .val(c_val));

    logic [33:0] rxy_d;
    logic [35:0] cxy_d;
    logic signed [16:0] e_rx, e_ry;
    logic signed [17:0] f_cx, f_cy;

    sqvt_dly #(.W(34), .N(4)) u_rxy_dly (
        .clk(clk), .adv(adv), .d({a_rx_reg, a_ry_reg}), .q(rxy_d));
    sqvt_dly #(.W(36), .N(5)) u_cxy_dly (
        .clk(clk), .adv(adv), .d({a_cx_reg, a_cy_reg}), .q(cxy_d));

    assign e_rx = $signed(rxy_d[33:17]);
    assign e_ry = $signed(rxy_d[16:0]);
    assign f_cx = $signed(cxy_d[35:18]);
    assign f_cy = $signed(cxy_d[17:0]);

    // ------------------------------------------------------------------
    // Stage 5: rotation products
    // ------------------------------------------------------------------
    logic signed [32:0] f_crx_reg, f_sry_reg, f_srx_reg, f_cry_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_crx_reg <= 33'(c_val) * 33'(e_rx);
            f_sry_reg <= 33'(s_val) * 33'(e_ry);
            f_srx_reg <= 33'(s_val) * 33'(e_rx);
            f_cry_reg <= 33'(c_val) * 33'(e_ry);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: position in Q.20; stage 7: division numerators
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] g_px_reg, g_py_reg;
    logic [NUM_W-1:0]      h_nx_reg, h_ny_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_px_reg <= (P_W'(f_cx) <<< 15) + P_W'(f_crx_reg) - P_W'(f_sry_reg);
            g_py_reg <= (P_W'(f_cy) <<< 15) + P_W'(f_srx_reg) + P_W'(f_cry_reg);
            h_nx_reg <= (NUM_W'(g_px_reg) << 1) + k_x;
            h_ny_reg <= (NUM_W'(g_py_reg) << 1) + k_y;
        end
    end

    logic [2*NUM_W-1:0] nuv_d;

    sqvt_dly #(.W(2*NUM_W), .N(7)) u_nuv_dly (
        .clk(clk), .adv(adv), .d({a_nu_reg, a_nv_reg}), .q(nuv_d));

    // ------------------------------------------------------------------
    // Stages 8-25: four dividers side by side
    // ------------------------------------------------------------------
    div_res_t r_x, r_y, r_u, r_v;

    sqvt_div u_div_x (.clk(clk), .adv(adv), .num(h_nx_reg), .den(den_x), .res(r_x));
    sqvt_div u_div_y (.clk(clk), .adv(adv), .num(h_ny_reg), .den(den_y), .res(r_y));
    sqvt_div u_div_u (.clk(clk), .adv(adv), .num(nuv_d[2*NUM_W-1:NUM_W]),
                      .den(den_u), .res(r_u));
    sqvt_div u_div_v (.clk(clk), .adv(adv), .num(nuv_d[NUM_W-1:0]),
                      .den(den_v), .res(r_v));

    logic [33:0] side_d;

    sqvt_dly #(.W(34), .N(25)) u_side_dly (
        .clk(clk), .adv(adv), .d({a_corner_reg, a_color_reg}), .q(side_d));

    // ------------------------------------------------------------------
    // Stage 26: saturate and hold the vertex word
    // ------------------------------------------------------------------
    logic signed [19:0] qx, qy, qu, qv;
    vertex_t            vtx_next, vtx_reg;

    assign qx = div_val(r_x);
    assign qy = div_val(r_y);
    assign qu = div_val(r_u);
    assign qv = div_val(r_v);

    always_comb
    begin
        vtx_next.corner_index = side_d[33:32];
        vtx_next.vertex_color = side_d[31:0];
        vtx_next.last_corner  = (side_d[33:32] == CORNER_BR);

        if (r_x.lo)
            vtx_next.ndc_x = SAT_MIN;
        else if (r_x.hi)
            vtx_next.ndc_x = SAT_MAX;
        else
            vtx_next.ndc_x = sat16(qx - 20'sd16384);

        // y points down on screen and up in NDC
        if (r_y.lo)
            vtx_next.ndc_y = SAT_MAX;
        else if (r_y.hi)
            vtx_next.ndc_y = SAT_MIN;
        else
            vtx_next.ndc_y = sat16(20'sd16384 - qy);

        if (r_u.lo)
            vtx_next.tex_u = SAT_MIN;
        else if (r_u.hi)
            vtx_next.tex_u = SAT_MAX;
        else
            vtx_next.tex_u = sat16(qu);

        if (r_v.lo)
            vtx_next.tex_v = SAT_MIN;
        else if (r_v.hi)
            vtx_next.tex_v = SAT_MAX;
        else
            vtx_next.tex_v = sat16(qv);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            vtx_reg <= vtx_next;
    end

    assign vertex       = vtx_reg;
    assign vertex_valid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_hold_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (spr_vld_reg && !adv) |=> ($stable(corner_reg) && spr_vld_reg))
        else $error("corner issuer moved during a stall");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (spr_vld_reg && corner_reg != CORNER_BR) |-> !sprite_ready)
        else $error("sprite word taken before its last corner issued");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NST-1] && !vertex_ready) |=> vld_reg[NST-1])
        else $error("held vertex word dropped");

endmodule

// File: tb/sv/sqvt_vertex_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sqvt_vertex_checker: vertex prediction and comparison for the quad unit
// Watches the sprite, vertex and register channels, predicts four vertex
// words per accepted sprite and compares them in order with the vertex words.
// ============================================================================
module sqvt_vertex_checker #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sprite_valid,
    input  logic                           sprite_ready,
    input  sqvt_pkg::sprite_t              sprite,
    input  logic                           vertex_valid,
    input  logic                           vertex_ready,
    input  sqvt_pkg::vertex_t              vertex,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sqvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sqvt_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending
);
    import sqvt_pkg::*;

    logic [CFG_DAT_W-1:0] scr_w, scr_h, tex_w, tex_h;
    vertex_t              expected_vertices[$];

    assign pending = expected_vertices.size();

    function automatic longint quarter_wave(longint r);
        longint x, x2, t, y;
        x  = r * 2;
        x2 = (x * x) >>> 15;
        t  = 10512 - ((1160 * x2) >>> 15);
        t  = 25736 - ((t * x2) >>> 15);
        y  = (x * t) >>> 14;
        return (y > 32767) ? 32767 : y;
    endfunction

    function automatic longint sine_at(longint phase);
        longint p, q, r, f;
        p = phase & 16'hFFFF;
        q = p >> 14;
        r = p & 16'h3FFF;
        if (q % 2 == 1)
            r = 16384 - r;
        f = quarter_wave(r);
        return (q >= 2) ? -f : f;
    endfunction

    // nearest, ties toward +infinity; d is always positive here
    function automatic longint round_near(longint n, longint d);
        longint num, den, q;
        num = 2 * n + d;
        den = 2 * d;
        q = num / den;
        if (num % den != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic longint used_size(logic [CFG_DAT_W-1:0] r);
        return (r == 0) ? 1 : longint'(r);
    endfunction

    task automatic predict_corners(sprite_t s);
        longint  dx, dy, dw, dh, sx, sy, sw, sh, phase, sn, cs;
        longint  cx, cy, rx, ry, px, py, su, sv, w, h, tw, th;
        vertex_t v;
        dx = $signed(s.dest_x);
        dy = $signed(s.dest_y);
        dw = $signed(s.dest_w);
        dh = $signed(s.dest_h);
        sx = $signed(s.src_x);
        sy = $signed(s.src_y);
        sw = $signed(s.src_w);
        sh = $signed(s.src_h);
        phase = (longint'(s.turn_angle) >> (16 - TRIG_TABLE_BITS)) << (16 - TRIG_TABLE_BITS);
        sn = sine_at(phase);
        cs = sine_at(phase + 16384);
        w  = used_size(scr_w);
        h  = used_size(scr_h);
        tw = used_size(tex_w);
        th = used_size(tex_h);
        cx = (2 * dx + dw) * 32768;
        cy = (2 * dy + dh) * 32768;
        for (int k = 0; k < 4; k++)
        begin
            rx = k[0] ? dw : -dw;
            ry = k[1] ? dh : -dh;
            px = cx + cs * rx - sn * ry;
            py = cy + sn * rx + cs * ry;
            su = k[0] ? sx + sw : sx;
            sv = k[1] ? sy + sh : sy;
            v.corner_index = k[1:0];
            v.ndc_x        = clamp16(round_near(px, 32 * w) - 16384);
            v.ndc_y        = clamp16(16384 - round_near(py, 32 * h));
            v.tex_u        = clamp16(round_near(su * 256, tw));
            v.tex_v        = clamp16(round_near(sv * 256, th));
            v.vertex_color = s.color_rgba;
            v.last_corner  = (k[1:0] == CORNER_BR);
            expected_vertices.push_back(v);
        end
    endtask

    task automatic compare_vertex(vertex_t got);
        vertex_t e;
        if (expected_vertices.size() == 0)
        begin
            $error("vertex word with none expected: %h", got);
            mismatches++;
            return;
        end
        e = expected_vertices.pop_front();
        if (got.corner_index !== e.corner_index)
        begin
            $error("corner_index exp %0d got %0d", e.corner_index, got.corner_index);
            mismatches++;
        end
        if (got.ndc_x !== e.ndc_x)
        begin
            $error("ndc_x exp %0d got %0d", e.ndc_x, got.ndc_x);
            mismatches++;
        end
        if (got.ndc_y !== e.ndc_y)
        begin
            $error("ndc_y exp %0d got %0d", e.ndc_y, got.ndc_y);
            mismatches++;
        end
        if (got.tex_u !== e.tex_u)
        begin
            $error("tex_u exp %0d got %0d", e.tex_u, got.tex_u);
            mismatches++;
        end
        if (got.tex_v !== e.tex_v)
        begin
            $error("tex_v exp %0d got %0d", e.tex_v, got.tex_v);
            mismatches++;
        end
        if (got.vertex_color !== e.vertex_color)
        begin
            $error("vertex_color exp %h got %h", e.vertex_color, got.vertex_color);
            mismatches++;
        end
        if (got.last_corner !== e.last_corner)
        begin
            $error("last_corner exp %0d got %0d", e.last_corner, got.last_corner);
            mismatches++;
        end
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w <= 13'd1280;
            scr_h <= 13'd720;
            tex_w <= 13'd8;
            tex_h <= 13'd8;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCREEN_W: scr_w <= cfg_data;
                    REG_SCREEN_H: scr_h <= cfg_data;
                    REG_TEX_W:    tex_w <= cfg_data;
                    REG_TEX_H:    tex_h <= cfg_data;
                    default: ;
                endcase
            end
            if (sprite_valid && sprite_ready)
                predict_corners(sprite);
            if (vertex_valid && vertex_ready)
                compare_vertex(vertex);
        end
    end

endmodule

// File: tb/sv/tb_sprite_quad_vertex_transform_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sprite_quad_vertex_transform_unit: stimulus and verdict for the quad unit
// Drives directed and random sprite words under several register settings
// and idle patterns; the checker predicts and compares every vertex word.
// ============================================================================
module tb_sprite_quad_vertex_transform_unit;
    import sqvt_pkg::*;

    localparam int DRAIN_CYCLES = 40;       // margin above the pipeline latency
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int PHASE_ITEMS  = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sprite_valid = 1'b0;
    logic                 sprite_ready;
    sprite_t              sprite = '0;
    logic                 vertex_valid;
    logic                 vertex_ready = 1'b0;
    vertex_t              vertex;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    int tx_idle_pct = 37;
    int rx_idle_pct = 60;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int cycles = 0;

    sprite_quad_vertex_transform_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .sprite       (sprite),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sqvt_vertex_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .sprite       (sprite),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random ready, or a long hold-off when asked for one.
    // Exactly one assignment to vertex_ready per edge.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            vertex_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            vertex_ready <= 1'b0;
        end
        else
        begin
            vertex_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one sprite word and hold it until taken. Valid stays high
    // between back-to-back words; drop it only when an idle gap is drawn.
    task automatic send_sprite(sprite_t s);
        int gap;
        bit rdy;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sprite_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite_valid <= 1'b1;
        sprite       <= s;
        // ready is sampled mid-cycle, where it is settled for the next edge
        do
        begin
            @(negedge clk);
            rdy = sprite_ready;
            @(posedge clk);
        end while (!rdy);
    endtask

    // Drop valid and wait for every expected vertex word to come out
    task automatic drain;
        sprite_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_sizes(int sw, int sh, int tw, int th);
        write_reg(REG_SCREEN_W, sw[CFG_DAT_W-1:0]);
        write_reg(REG_SCREEN_H, sh[CFG_DAT_W-1:0]);
        write_reg(REG_TEX_W, tw[CFG_DAT_W-1:0]);
        write_reg(REG_TEX_H, th[CFG_DAT_W-1:0]);
        // unused index, must leave every size alone
        write_reg(CFG_IDX_W'(REG_TEX_H + 1 + $urandom_range(3)),
                  CFG_DAT_W'($urandom_range(8191)));
    endtask

    // Mostly on-screen sprites with modest sizes, the rest full-range noise
    function automatic sprite_t random_sprite();
        sprite_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        if ($urandom_range(99) < 70)
        begin
            s.dest_x = $signed(16'($urandom_range(20480))) - 16'sd1024;
            s.dest_y = $signed(16'($urandom_range(12288))) - 16'sd1024;
            s.dest_w = $signed(16'($urandom_range(4096))) - 16'sd512;
            s.dest_h = $signed(16'($urandom_range(4096))) - 16'sd512;
            s.src_x  = $signed(16'($urandom_range(2048))) - 16'sd256;
            s.src_y  = $signed(16'($urandom_range(2048))) - 16'sd256;
            s.src_w  = $signed(16'($urandom_range(1024))) - 16'sd128;
            s.src_h  = $signed(16'($urandom_range(1024))) - 16'sd128;
        end
        return s;
    endfunction

    function automatic sprite_t fill_sprite(logic [15:0] geo, logic [15:0] ang,
                                            logic [31:0] col);
        sprite_t s;
        s = {geo, geo, geo, geo, geo, geo, geo, geo, ang, col};
        return s;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_sprite(random_sprite());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, cardinal angles, table truncation,
        // negative sizes, all at the reset sizes
        send_sprite(fill_sprite(16'h0000, 16'h0000, 32'h0000_0000));
        send_sprite(fill_sprite(16'h7FFF, 16'h0000, 32'hFFFF_FFFF));
        send_sprite(fill_sprite(16'h8000, 16'hFFFF, 32'h8000_0001));
        send_sprite(fill_sprite(16'h0100, 16'h4000, 32'h1234_5678));
        send_sprite(fill_sprite(16'h0100, 16'h8000, 32'hA5A5_5A5A));
        send_sprite(fill_sprite(16'h0100, 16'hC000, 32'h5A5A_A5A5));
        send_sprite(fill_sprite(16'h0100, 16'h003F, 32'h0F0F_0F0F));
        send_sprite(fill_sprite(16'h0100, 16'h0040, 32'hF0F0_F0F0));
        send_sprite(fill_sprite(16'hFF00, 16'h2000, 32'h0000_00FF));
        send_sprite('{16'sh2800, 16'sh1680, -16'sh0400, -16'sh0300,
                      16'sh0000, 16'sh0080, -16'sh0080, 16'sh7FFF,
                      16'h6000, 32'hDEAD_BEEF});
        send_sprite('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                      16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                      16'hE000, 32'hCAFE_F00D});
        drain();

        // Size extremes: smallest, zero, largest
        set_sizes(1, 1, 1, 1);
        for (int i = 0; i < 6; i++)
            send_sprite(fill_sprite(16'($urandom), 16'($urandom), $urandom));
        drain();
        set_sizes(0, 8191, 0, 8191);
        run_random(6);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            tx_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 60 : 0;
            rx_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 37 : 0;
            case (ph)
                0: set_sizes(4096, 4096, 4096, 4096);
                1: set_sizes(8191, 0, 8191, 0);
                2: set_sizes(640, 480, 256, 256);
                3: set_sizes($urandom_range(1, 4096), $urandom_range(1, 4096),
                             $urandom_range(1, 4096), $urandom_range(1, 4096));
                4: set_sizes(1280, 720, 64, 32);
                default: set_sizes(1920, 1080, 1, 4096);
            endcase
            // fill the pipe behind a stalled receiver
            if (ph == 5)
                hold_req = 1'b1;
            run_random(PHASE_ITEMS / 2);
            // pause the sender until everything in flight has come out
            sprite_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            run_random(PHASE_ITEMS / 2);
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
